@@ design/u8dw_pkg.sv @@
// Package for the UTF-8 display width block: shared types, byte codes and
// the code point column width function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package u8dw_pkg;

    localparam logic [7:0] LEAD2_LO  = 8'hC2;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF4;
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] SEQ_LEN2  = 3'd2;
    localparam logic [2:0] SEQ_LEN3  = 3'd3;
    localparam logic [2:0] SEQ_LEN4  = 3'd4;
    localparam int         CP_BITS   = 21;
    localparam int         INC_BITS  = 3;
    localparam int         OUT_BITS  = 16;

    typedef logic [CP_BITS-1:0] code_point_t;

    // one entry per accepted byte: columns it settles, end of string mark
    typedef struct packed {
        logic [INC_BITS-1:0] cols;
        logic                last;
    } u8dw_item_t;

    function automatic logic [1:0] cp_width(input code_point_t cp);
        logic [1:0] w;
        begin
            w = 2'd1;
            if (cp inside {[21'h00000:21'h0001F], [21'h0007F:21'h0009F],
                           [21'h00300:21'h0036F], [21'h01AB0:21'h01AFF],
                           [21'h020D0:21'h020FF], [21'h0FE00:21'h0FE0F]})
                w = 2'd0;
            else if (cp inside {[21'h01100:21'h0115F], [21'h02E80:21'h0303E],
                                [21'h03041:21'h033FF], [21'h03400:21'h04DBF],
                                [21'h04E00:21'h09FFF], [21'h0A000:21'h0A4CF],
                                [21'h0AC00:21'h0D7A3], [21'h0F900:21'h0FAFF],
                                [21'h0FE30:21'h0FE4F], [21'h0FF00:21'h0FF60],
                                [21'h0FFE0:21'h0FFE6], [21'h20000:21'h2FFFD],
                                [21'h30000:21'h3FFFD]})
                w = 2'd2;
            return w;
        end
    endfunction

endpackage
`default_nettype wire

@@ design/u8dw_if.sv @@
// Channel interfaces of the UTF-8 display width block: byte input and
// column total result. Valid/ready handshake; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface u8dw_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       last_byte;

    modport source (output valid, output byte_in, output last_byte, input ready);
    modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

interface u8dw_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] total_columns;

    modport source (output valid, output total_columns, input ready);
    modport sink   (input valid, input total_columns, output ready);
endinterface
`default_nettype wire

@@ design/u8dw_front.sv @@
// Front end: UTF-8 sequence decoder that turns each byte into the column
// count it settles. Depends on u8dw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u8dw_front
    import u8dw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [7:0] byte_in,
    input  wire logic       last_byte,
    input  wire logic       push_ready,
    output      logic       push_valid,
    output      u8dw_item_t push_item
);

    logic [1:0]  held_reg, held_next;
    logic [2:0]  seq_reg, seq_next;
    code_point_t acc_reg, acc_next;

    logic [1:0]  held_w;
    logic [2:0]  seq_w;
    code_point_t acc_w;
    code_point_t acc_cont;
    logic [2:0]  held_inc;
    logic [1:0]  cont_cols;
    logic [1:0]  held_cols;
    logic [1:0]  lead_cols;
    logic        lead_go;
    logic        fire;

    assign fire       = in_valid && push_ready;
    assign push_valid = in_valid;
    assign acc_cont   = {acc_reg[CP_BITS-7:0], byte_in[5:0]};
    assign held_inc   = {1'b0, held_reg} + 3'd1;

    always_comb
    begin
        held_w    = held_reg;
        seq_w     = seq_reg;
        acc_w     = acc_reg;
        cont_cols = 2'd0;
        held_cols = 2'd0;
        lead_cols = 2'd0;
        lead_go   = 1'b0;

        if (held_reg == 2'd0)
        begin
            lead_go = 1'b1;
        end
        else if (byte_in[7:6] == CONT_TAG)
        begin
            if (held_inc >= seq_reg)
            begin
                cont_cols = cp_width(acc_cont);
                held_w    = 2'd0;
                seq_w     = 3'd0;
                acc_w     = '0;
            end
            else
            begin
                held_w = held_inc[1:0];
                acc_w  = acc_cont;
            end
        end
        else
        begin
            held_cols = held_reg;
            held_w    = 2'd0;
            seq_w     = 3'd0;
            acc_w     = '0;
            lead_go   = 1'b1;
        end

        if (lead_go)
        begin
            if (byte_in == 8'h00)
                lead_cols = 2'd1;
            else if (byte_in[7] == 1'b0)
                lead_cols = cp_width({{(CP_BITS-8){1'b0}}, byte_in});
            else if (byte_in inside {[LEAD2_LO:LEAD2_HI]})
            begin
                held_w = 2'd1;
                seq_w  = SEQ_LEN2;
                acc_w  = {{(CP_BITS-5){1'b0}}, byte_in[4:0]};
            end
            else if (byte_in inside {[LEAD3_LO:LEAD3_HI]})
            begin
                held_w = 2'd1;
                seq_w  = SEQ_LEN3;
                acc_w  = {{(CP_BITS-4){1'b0}}, byte_in[3:0]};
            end
            else if (byte_in inside {[LEAD4_LO:LEAD4_HI]})
            begin
                held_w = 2'd1;
                seq_w  = SEQ_LEN4;
                acc_w  = {{(CP_BITS-3){1'b0}}, byte_in[2:0]};
            end
            else
                lead_cols = 2'd1;
        end
    end

    always_comb
    begin
        push_item.last = last_byte;
        push_item.cols = {1'b0, cont_cols} + {1'b0, held_cols} + {1'b0, lead_cols};
        held_next      = held_w;
        seq_next       = seq_w;
        acc_next       = acc_w;
        if (last_byte)
        begin
            // truncated sequence at end of string: one column per held byte
            push_item.cols = push_item.cols + {1'b0, held_w};
            held_next      = 2'd0;
            seq_next       = 3'd0;
            acc_next       = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 2'd0;
            seq_reg  <= 3'd0;
            acc_reg  <= '0;
        end
        else if (fire)
        begin
            held_reg <= held_next;
            seq_reg  <= seq_next;
            acc_reg  <= acc_next;
        end
    end

endmodule
`default_nettype wire

@@ design/u8dw_queue.sv @@
// Two-entry queue between the decoder and the column accumulator.
// Depends on u8dw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u8dw_queue
    import u8dw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push_valid,
    input  wire u8dw_item_t push_item,
    output      logic       push_ready,
    output      logic       pop_valid,
    output      u8dw_item_t pop_item,
    input  wire logic       pop_ready
);

    u8dw_item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ design/u8dw_back.sv @@
// Back end: saturating column accumulator and result register.
// Depends on u8dw_pkg.
`timescale 1ns / 1ps
`default_nettype none
module u8dw_back
    import u8dw_pkg::*;
#(
    parameter int SUM_BITS = 16
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                pop_valid,
    input  wire u8dw_item_t          pop_item,
    output      logic                pop_ready,
    output      logic                out_valid,
    output      logic [OUT_BITS-1:0] total_columns,
    input  wire logic                out_ready
);

    logic [SUM_BITS-1:0] sum_reg, sum_next;
    logic [OUT_BITS-1:0] total_reg, total_next;
    logic                valid_reg, valid_next;
    logic [SUM_BITS:0]   sum_wide;
    logic [SUM_BITS-1:0] sum_sat;
    logic [OUT_BITS-1:0] sum_out;
    logic                pop;

    assign sum_wide = {1'b0, sum_reg} + (SUM_BITS+1)'(pop_item.cols);
    assign sum_sat  = sum_wide[SUM_BITS] ? {SUM_BITS{1'b1}} : sum_wide[SUM_BITS-1:0];

    generate
        if (SUM_BITS >= OUT_BITS)
        begin : g_trunc
            assign sum_out = sum_sat[OUT_BITS-1:0];
        end
        else
        begin : g_ext
            assign sum_out = {{(OUT_BITS-SUM_BITS){1'b0}}, sum_sat};
        end
    endgenerate

    // stall only an end-of-string transaction while the result slot is busy
    assign pop_ready     = !pop_item.last || !valid_reg || out_ready;
    assign pop           = pop_valid && pop_ready;
    assign out_valid     = valid_reg;
    assign total_columns = total_reg;

    always_comb
    begin
        sum_next   = sum_reg;
        total_next = total_reg;
        valid_next = valid_reg && !out_ready;
        if (pop)
        begin
            if (pop_item.last)
            begin
                sum_next   = '0;
                total_next = sum_out;
                valid_next = 1'b1;
            end
            else
                sum_next = sum_sat;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg   <= sum_next;
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire

@@ design/utf8_display_width.sv @@
// UTF-8 display width, top level: decoder, queue and accumulator.
// Depends on u8dw_pkg, u8dw_if, u8dw_front, u8dw_queue, u8dw_back.
// Throughput: one byte per cycle while the queue is not full.
// Result path: the last byte's columns pass through the queue and then the
// result register, and wait longer while the result register is stalled.
// Reset: asynchronous; decoder state, queue and running sum clear to zero.
`timescale 1ns / 1ps
`default_nettype none
module utf8_display_width
    import u8dw_pkg::*;
#(
    parameter int SUM_BITS = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    u8dw_in_if.sink     in_ch,
    u8dw_out_if.source  out_ch
);

    logic       push_valid;
    logic       push_ready;
    u8dw_item_t push_item;
    logic       pop_valid;
    logic       pop_ready;
    u8dw_item_t pop_item;

    assign in_ch.ready = push_ready;

    u8dw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .byte_in    (in_ch.byte_in),
        .last_byte  (in_ch.last_byte),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    u8dw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    u8dw_back #(
        .SUM_BITS (SUM_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_item      (pop_item),
        .pop_ready     (pop_ready),
        .out_valid     (out_ch.valid),
        .total_columns (out_ch.total_columns),
        .out_ready     (out_ch.ready)
    );

endmodule
`default_nettype wire

@@ design/u8dw_checker.sv @@
// Port-level checks for utf8_display_width, attached by bind.
// Depends on the top level's channel ports only.
`timescale 1ns / 1ps
`default_nettype none
module u8dw_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] total_columns
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(total_columns))
        else $error("result changed while stalled");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result shown during reset");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
        else $error("input stalled without a stalled result");

endmodule

bind utf8_display_width u8dw_checker u_u8dw_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ch.ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .total_columns (out_ch.total_columns)
);
`default_nettype wire

@@ verif/utf8_display_width_tb.sv @@
// Testbench for utf8_display_width: drives byte strings over the input channel
// and checks each column total against a predictor or a pinned directed total.
// Depends on u8dw_pkg, u8dw_in_if, u8dw_out_if and the utf8_display_width RTL.
`timescale 1ns / 1ps
module utf8_display_width_tb
    import u8dw_pkg::*;
();

    localparam int CLK_PERIOD   = 10;
    localparam int SUM_W        = 16;
    localparam int RANDOM_BYTES = 1800;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int IDLE_PCT     = 22;
    localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;

    typedef struct {
        logic [7:0]  data;
        logic        last;
        bit          pinned;
        logic [15:0] total;
    } byte_row_t;

    byte_row_t directed_rows [0:24] = '{
        '{8'h00, 1'b1, 1'b1, 16'd1},
        '{8'h41, 1'b1, 1'b1, 16'd1},
        '{8'h7F, 1'b1, 1'b1, 16'd0},
        '{8'hFF, 1'b1, 1'b1, 16'd1},
        '{8'h80, 1'b1, 1'b1, 16'd1},
        '{8'hF5, 1'b1, 1'b1, 16'd1},
        '{8'hC2, 1'b0, 1'b0, 16'd0},
        '{8'hA0, 1'b1, 1'b0, 16'd0},
        '{8'hCC, 1'b0, 1'b0, 16'd0},
        '{8'h80, 1'b1, 1'b0, 16'd0},
        '{8'hE4, 1'b0, 1'b0, 16'd0},
        '{8'hB8, 1'b0, 1'b0, 16'd0},
        '{8'h80, 1'b1, 1'b0, 16'd0},
        '{8'hF0, 1'b0, 1'b0, 16'd0},
        '{8'hA0, 1'b0, 1'b0, 16'd0},
        '{8'h80, 1'b0, 1'b0, 16'd0},
        '{8'h80, 1'b1, 1'b0, 16'd0},
        '{8'hF4, 1'b0, 1'b0, 16'd0},
        '{8'h8F, 1'b0, 1'b0, 16'd0},
        '{8'hBF, 1'b0, 1'b0, 16'd0},
        '{8'hBF, 1'b1, 1'b0, 16'd0},
        '{8'hE4, 1'b0, 1'b0, 16'd0},
        '{8'h41, 1'b1, 1'b1, 16'd2},
        '{8'hF0, 1'b0, 1'b0, 16'd0},
        '{8'h90, 1'b1, 1'b1, 16'd2}
    };

    int unsigned cp_edges [0:35] = '{
        'h20, 'h7F, 'hA0, 'h300, 'h370, 'h1100, 'h1160, 'h1AB0, 'h1B00, 'h20D0,
        'h2100, 'h2E80, 'h303F, 'h3041, 'h3400, 'h4DC0, 'h4E00, 'hA000, 'hA4D0,
        'hAC00, 'hD7A4, 'hF900, 'hFB00, 'hFE00, 'hFE10, 'hFE30, 'hFE50, 'hFF00,
        'hFF61, 'hFFE0, 'hFFE7, 'h20000, 'h2FFFE, 'h30000, 'h3FFFE, 'h10FFFF
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    u8dw_in_if  in_ch ();
    u8dw_out_if out_ch ();

    utf8_display_width #(
        .SUM_BITS (SUM_W)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    int unsigned     held_cnt = 0;
    int unsigned     seq_len = 0;
    logic [20:0]     cp_acc = '0;
    longint unsigned col_sum = 0;

    logic [15:0] expected_totals [$];
    logic [7:0]  text_bytes [$];
    logic [15:0] want_total;
    int          errors = 0;
    int          cycle_count = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    function automatic int unsigned glyph_width(input logic [20:0] cp);
        if (cp < 'h20 || (cp >= 'h7F && cp < 'hA0))
            return 0;
        if ((cp >= 'h0300 && cp <= 'h036F) || (cp >= 'h1AB0 && cp <= 'h1AFF) ||
            (cp >= 'h20D0 && cp <= 'h20FF) || (cp >= 'hFE00 && cp <= 'hFE0F))
            return 0;
        if ((cp >= 'h1100 && cp <= 'h115F) || (cp >= 'h2E80 && cp <= 'h303E) ||
            (cp >= 'h3041 && cp <= 'h33FF) || (cp >= 'h3400 && cp <= 'h4DBF) ||
            (cp >= 'h4E00 && cp <= 'h9FFF) || (cp >= 'hA000 && cp <= 'hA4CF) ||
            (cp >= 'hAC00 && cp <= 'hD7A3) || (cp >= 'hF900 && cp <= 'hFAFF) ||
            (cp >= 'hFE30 && cp <= 'hFE4F) || (cp >= 'hFF00 && cp <= 'hFF60) ||
            (cp >= 'hFFE0 && cp <= 'hFFE6) || (cp >= 'h20000 && cp <= 'h2FFFD) ||
            (cp >= 'h30000 && cp <= 'h3FFFD))
            return 2;
        return 1;
    endfunction

    task automatic add_columns(input int unsigned n);
        col_sum = (col_sum + n > SUM_MAX) ? SUM_MAX : col_sum + n;
    endtask

    task automatic clear_char();
        held_cnt = 0;
        seq_len = 0;
        cp_acc = '0;
    endtask

    task automatic open_char(input logic [7:0] b);
        if (b == 8'h00) begin
            add_columns(1);
        end else if (b < 8'h80) begin
            add_columns(glyph_width({13'd0, b}));
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            held_cnt = 1;
            seq_len = SEQ_LEN2;
            cp_acc = {16'd0, b[4:0]};
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            held_cnt = 1;
            seq_len = SEQ_LEN3;
            cp_acc = {17'd0, b[3:0]};
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            held_cnt = 1;
            seq_len = SEQ_LEN4;
            cp_acc = {18'd0, b[2:0]};
        end else begin
            add_columns(1);
        end
    endtask

    task automatic predict_columns(input logic [7:0] b, input logic last,
                                   output bit has_total, output logic [15:0] total);
        has_total = 1'b0;
        total = '0;
        if (held_cnt == 0) begin
            open_char(b);
        end else if (b[7:6] == CONT_TAG) begin
            cp_acc = {cp_acc[14:0], b[5:0]};
            held_cnt++;
            if (held_cnt >= seq_len) begin
                add_columns(glyph_width(cp_acc));
                clear_char();
            end
        end else begin
            add_columns(held_cnt);
            clear_char();
            open_char(b);
        end
        if (last) begin
            add_columns(held_cnt);
            has_total = 1'b1;
            total = col_sum[15:0];
            clear_char();
            col_sum = 0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        errors++;
        if (errors <= 40)
            $display("MISMATCH at cycle %0d: %s, got %0d, expected %0d",
                     cycle_count, what, got, want);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit pinned, input logic [15:0] pinned_total);
        bit          has_total;
        logic [15:0] total;
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.byte_in   <= b;
        in_ch.last_byte <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_columns(b, last, has_total, total);
        if (has_total)
            expected_totals.push_back(pinned ? pinned_total : total);
    endtask

    task automatic wait_for_totals();
        in_ch.valid <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_utf8(input int unsigned cp, input int len);
        logic [20:0] c;
        c = cp[20:0];
        case (len)
            1: text_bytes.push_back(c[7:0]);
            2: begin
                text_bytes.push_back({3'b110, c[10:6]});
                text_bytes.push_back({2'b10, c[5:0]});
            end
            3: begin
                text_bytes.push_back({4'b1110, c[15:12]});
                text_bytes.push_back({2'b10, c[11:6]});
                text_bytes.push_back({2'b10, c[5:0]});
            end
            default: begin
                text_bytes.push_back({5'b11110, c[20:18]});
                text_bytes.push_back({2'b10, c[17:12]});
                text_bytes.push_back({2'b10, c[11:6]});
                text_bytes.push_back({2'b10, c[5:0]});
            end
        endcase
    endtask

    // mostly well-formed text; some noise bytes, overlong forms and cut sequences
    task automatic build_string();
        int          n_chars;
        int          r;
        int          c;
        int          len;
        int unsigned cp;
        text_bytes.delete();
        n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        repeat (n_chars) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                text_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                c = $urandom_range(0, 99);
                if (c < 25)
                    cp = $urandom_range(0, 'h7F);
                else if (c < 60)
                    cp = cp_edges[$urandom_range(0, 35)] - 1 + $urandom_range(0, 2);
                else if (c < 72)
                    cp = $urandom_range('h80, 'h7FF);
                else if (c < 88)
                    cp = $urandom_range('h800, 'hFFFF);
                else
                    cp = $urandom_range('h10000, 'h140000);
                len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
                if (len < 4 && $urandom_range(0, 19) == 0)
                    len = $urandom_range(len + 1, 4);
                push_utf8(cp, len);
                if (r < 16 && len > 1)
                    repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
            end
        end
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_totals.size() == 0) begin
                report_mismatch("total with none pending", out_ch.total_columns, 16'd0);
            end else begin
                want_total = expected_totals.pop_front();
                if (out_ch.total_columns !== want_total)
                    report_mismatch("total_columns", out_ch.total_columns, want_total);
            end
        end
    end

    initial
    begin
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    initial
    begin
        int sent;
        int strings;
        in_ch.valid     <= 1'b0;
        in_ch.byte_in   <= 8'h00;
        in_ch.last_byte <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].pinned, directed_rows[i].total);
        wait_for_totals();

        sent = 0;
        strings = 0;
        while (sent < RANDOM_BYTES)
        begin
            build_string();
            if (strings == 20)
                hold_req = 1'b1;
            if (strings == 50)
                wait_for_totals();
            // run both sides with no idling for a stretch of strings
            if (strings == 60)
                quiet = 1'b1;
            if (strings == 80)
                quiet = 1'b0;
            foreach (text_bytes[i])
                send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, 16'd0);
            sent += text_bytes.size();
            strings++;
        end
        quiet = 1'b0;

        wait_for_totals();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
